// ----- src/assert_macros.svh -----
// Assertion macros used by bounded_ordered_list.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- src/bol_pkg.sv -----
`default_nettype none

package bol_pkg;

   // Default number of list cells.
   localparam int CAPACITY_DEFAULT = 16;

   // Width of one stored value.
   localparam int DATA_W = 32;

   // Command codes on the request channel.
   typedef enum logic [2:0] {
      CMD_ADD_FRONT = 3'd0,
      CMD_ADD_REAR  = 3'd1,
      CMD_DELETE    = 3'd2,
      CMD_READ      = 3'd3,
      CMD_CLEAR     = 3'd4
   } cmd_type;

   // Status codes on the response channel.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   // Operation broadcast to every cell in a cycle.
   typedef enum logic [2:0] {
      OP_HOLD       = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_REAR  = 3'd2,
      OP_DELETE     = 3'd3,
      OP_ROTATE     = 3'd4
   } cell_op_type;

   // Control word that travels from the controller to the cell row.
   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- src/bol_cell.sv -----
`default_nettype none

// One list position. It holds a single value and loads from its lower or
// upper neighbor, from the broadcast word, or from the head of the list.
module bol_cell #(
   parameter int Idx  = 0,
   parameter int CntW = 5
) (
   input  wire                                 clock,
   input  wire  bol_pkg::cell_ctrl_type        ctrl,
   input  wire  [CntW-1:0]                     count,
   input  wire  signed [bol_pkg::DATA_W-1:0]   lo_value,
   input  wire  signed [bol_pkg::DATA_W-1:0]   hi_value,
   input  wire  signed [bol_pkg::DATA_W-1:0]   head_value,
   input  wire                                 hit_in,
   output logic                                hit_out,
   output logic signed [bol_pkg::DATA_W-1:0]   value
);

   logic signed [bol_pkg::DATA_W-1:0] value_ff;
   logic signed [bol_pkg::DATA_W-1:0] value_in;
   logic                              occupied;
   logic                              tail;
   logic                              vacant_next;

   // Position flags relative to the current fill level.
   assign occupied    = count > CntW'(Idx);
   assign tail        = count == CntW'(Idx + 1);
   assign vacant_next = count == CntW'(Idx);

   // A hit here or in any earlier cell makes this cell close up.
   assign hit_out = hit_in | (occupied && (value_ff == ctrl.value));

   // Next value of this position.
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         bol_pkg::OP_PUSH_FRONT: value_in = lo_value;
         bol_pkg::OP_PUSH_REAR: begin
            if (vacant_next) value_in = ctrl.value;
         end
         bol_pkg::OP_DELETE: begin
            if (hit_out) value_in = hi_value;
         end
         bol_pkg::OP_ROTATE: value_in = tail ? head_value : hi_value;
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ----- src/bounded_ordered_list.sv -----
`default_nettype none
`include "assert_macros.svh"

// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+-------------------------
// request   | req_cmd, req_item_value                            | start high, busy low
// response  | rsp_out_value, rsp_out_valid, rsp_last,            | rsp_strobe, one cycle
//           | rsp_entry_count, rsp_status                        |
//
// An edit, clear or unknown command acts on the cell row in the cycle it is
// accepted; its one word appears on the response ports in the next cycle,
// and a new command may start in that same cycle.
// A read-out of N entries rotates the cell row once per cycle and keeps busy
// high while it streams them, giving one word per cycle; an empty read-out gives
// a single word. Synchronous reset empties the list; stored values are not cleared.
// The receiver cannot stall: every response word is valid for one cycle only.
module bounded_ordered_list #(
   parameter int CAPACITY = bol_pkg::CAPACITY_DEFAULT,
   localparam int CntW    = $clog2(CAPACITY + 1),
   localparam int IdxW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire  [2:0]                         req_cmd,
   input  wire  signed [bol_pkg::DATA_W-1:0]  req_item_value,
   output logic                               rsp_strobe,
   output logic signed [bol_pkg::DATA_W-1:0]  rsp_out_value,
   output logic                               rsp_out_valid,
   output logic                               rsp_last,
   output logic [CntW-1:0]                    rsp_entry_count,
   output logic [1:0]                         rsp_status
);

   bol_pkg::state_type                state_ff;
   bol_pkg::state_type                state_in;
   logic [CntW-1:0]                   count_ff;
   logic [CntW-1:0]                   count_in;
   logic [IdxW-1:0]                   rd_idx_ff;
   logic [IdxW-1:0]                   rd_idx_in;
   logic                              rsp_strobe_ff;
   logic                              rsp_strobe_in;
   logic signed [bol_pkg::DATA_W-1:0] rsp_value_ff;
   logic signed [bol_pkg::DATA_W-1:0] rsp_value_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              rsp_last_ff;
   logic                              rsp_last_in;
   logic [CntW-1:0]                   rsp_count_ff;
   logic [CntW-1:0]                   rsp_count_in;
   logic [1:0]                        rsp_status_ff;
   logic [1:0]                        rsp_status_in;

   bol_pkg::cell_ctrl_type            ctrl;
   logic signed [bol_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic                              hit [CAPACITY+1];
   logic                              accept;
   logic                              full;
   logic                              found;
   logic                              read_end;

   assign busy     = (state_ff == bol_pkg::S_READ);
   assign accept   = start && !busy;
   assign full     = (count_ff == CntW'(CAPACITY));
   assign found    = hit[CAPACITY];
   assign read_end = (state_ff == bol_pkg::S_READ) &&
                     (CntW'(rd_idx_ff) == (count_ff - CntW'(1)));

   // Row of list cells, front at position zero.
   assign hit[0] = 1'b0;
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [bol_pkg::DATA_W-1:0] lo_value;
      logic signed [bol_pkg::DATA_W-1:0] hi_value;

      if (i == 0) begin : g_lo_front
         assign lo_value = ctrl.value;
      end else begin : g_lo_chain
         assign lo_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_hi_end
         assign hi_value = '0;
      end else begin : g_hi_chain
         assign hi_value = cell_value[i+1];
      end

      bol_cell #(
         .Idx  (i),
         .CntW (CntW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .lo_value   (lo_value),
         .hi_value   (hi_value),
         .head_value (cell_value[0]),
         .hit_in     (hit[i]),
         .hit_out    (hit[i+1]),
         .value      (cell_value[i])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bol_pkg::S_IDLE: begin
            if (accept && (bol_pkg::cmd_type'(req_cmd) == bol_pkg::CMD_READ) &&
                (count_ff != '0)) begin
               state_in = bol_pkg::S_READ;
            end
         end
         bol_pkg::S_READ: begin
            if (read_end) state_in = bol_pkg::S_IDLE;
         end
         default: state_in = bol_pkg::S_IDLE;
      endcase
   end

   // Cell control, count update and the response word.
   always_comb begin
      ctrl.op       = bol_pkg::OP_HOLD;
      ctrl.value    = req_item_value;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = '0;
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b1;
      rsp_status_in = bol_pkg::ST_OK;

      if (state_ff == bol_pkg::S_READ) begin
         // Stream the head and rotate the row by one place.
         ctrl.op       = bol_pkg::OP_ROTATE;
         rsp_strobe_in = 1'b1;
         rsp_value_in  = cell_value[0];
         rsp_valid_in  = 1'b1;
         rsp_last_in   = read_end;
         rd_idx_in     = rd_idx_ff + IdxW'(1);
      end else if (accept) begin
         case (bol_pkg::cmd_type'(req_cmd))
            bol_pkg::CMD_ADD_FRONT: begin
               rsp_strobe_in = 1'b1;
               if (full) begin
                  rsp_status_in = bol_pkg::ST_FULL;
               end else begin
                  ctrl.op  = bol_pkg::OP_PUSH_FRONT;
                  count_in = count_ff + CntW'(1);
               end
            end
            bol_pkg::CMD_ADD_REAR: begin
               rsp_strobe_in = 1'b1;
               if (full) begin
                  rsp_status_in = bol_pkg::ST_FULL;
               end else begin
                  ctrl.op  = bol_pkg::OP_PUSH_REAR;
                  count_in = count_ff + CntW'(1);
               end
            end
            bol_pkg::CMD_DELETE: begin
               rsp_strobe_in = 1'b1;
               ctrl.op       = bol_pkg::OP_DELETE;
               if (found) begin
                  count_in = count_ff - CntW'(1);
               end else begin
                  rsp_status_in = bol_pkg::ST_NOT_FOUND;
               end
            end
            bol_pkg::CMD_READ: begin
               rd_idx_in = '0;
               // An empty list answers at once with a single empty word.
               if (count_ff == '0) rsp_strobe_in = 1'b1;
            end
            bol_pkg::CMD_CLEAR: begin
               rsp_strobe_in = 1'b1;
               count_in      = '0;
            end
            default: begin
               rsp_strobe_in = 1'b1;
            end
         endcase
      end
      rsp_count_in = count_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bol_pkg::S_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_valid   = rsp_valid_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   // The fill level never passes the number of cells.
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CntW'(CAPACITY), "count over capacity")
   // A read-out sequence only runs over a non-empty list.
   `ASSERT_IMPLIES(a_read_nonempty, clock, reset, busy, (count_ff != '0) && (CntW'(rd_idx_ff) < count_ff), "read index out of range")
   // Every accepted command either answers next cycle or starts a read-out.
   `ASSERT_NEXT(a_accept_answers, clock, reset, accept, rsp_strobe || busy, "command gave no word")
   // The final word of a command leaves the block ready.
   `ASSERT_IMPLIES(a_last_frees, clock, reset, rsp_strobe && rsp_last, !busy, "busy after last word")
   // Words during a read-out carry a stored entry.
   `ASSERT_NEXT(a_read_valid, clock, reset, busy, rsp_strobe && rsp_out_valid, "read-out word missing")

endmodule

`default_nettype wire
